// ===== design/html_escape_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// HTML escape encoder assertion macros
// Shared property macros for the concurrent checks of the encoder.
// ----------------------------------------------------------------------------
`ifndef HTML_ESCAPE_ENCODER_DEFINES_SVH
`define HTML_ESCAPE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define HEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// HTML escape encoder package
// Types, character codes and the per-byte expansion function.
// ----------------------------------------------------------------------------
package hee_pkg;

  localparam int unsigned MaxRun = 6;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChNum1  = 8'd139;
  localparam logic [7:0] ChNum2  = 8'd155;

  typedef logic [2:0] run_len_t;

  // Expanded form of one input byte, byte 0 goes out first
  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    run_len_t               len;
  } run_t;

  // Expand one raw byte into its escaped byte run
  function automatic run_t hee_expand(logic [7:0] b, logic esc_all);
    run_t        r;
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    logic [2:0]  pos;
    r.bytes = '0;
    r.len   = 3'd1;
    // Split into decimal digits: compare for hundreds, reciprocal for tens
    hund = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    rem  = b - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    prod = 15'({7'd0, rem} * 15'd205);
    tens = prod[14:11];
    ones = rem - 8'({tens, 3'b000}) - 8'({tens, 1'b0});
    pos  = 3'd2;
    if (esc_all || b == ChNum1 || b == ChNum2) begin
      // Decimal numeric entity without leading zeros
      r.bytes[0] = ChAmp;
      r.bytes[1] = ChHash;
      if (b > 8'd99) begin
        r.bytes[pos] = ChZero + {6'd0, hund};
        pos          = pos + 3'd1;
      end
      if (b > 8'd9) begin
        r.bytes[pos] = ChZero + {4'd0, tens};
        pos          = pos + 3'd1;
      end
      r.bytes[pos] = ChZero + ones;
      pos          = pos + 3'd1;
      r.bytes[pos] = ChSemi;
      r.len        = pos + 3'd1;
    end else begin
      // Named entities, listed last byte first
      unique case (b)
        ChAmp: begin
          r.bytes = {8'd0, ChSemi, "p", "m", "a", ChAmp};
          r.len   = 3'd5;
        end
        ChLt: begin
          r.bytes = {8'd0, 8'd0, ChSemi, "t", "l", ChAmp};
          r.len   = 3'd4;
        end
        ChGt: begin
          r.bytes = {8'd0, 8'd0, ChSemi, "t", "g", ChAmp};
          r.len   = 3'd4;
        end
        ChQuot: begin
          r.bytes = {ChSemi, "t", "o", "u", "q", ChAmp};
          r.len   = 3'd6;
        end
        default: begin
          r.bytes[0] = b;
          r.len      = 3'd1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/html_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// HTML escape encoder
// Turns a stream of raw bytes into their HTML-escaped form, one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one raw byte per beat, tlast marks the final byte
//   of a message. Master stream m_axis_*: one escaped byte per beat, tuser
//   marks the last byte produced by one input byte, tlast the last byte of
//   the message. cfg_* writes escape_all (1: every byte as &#N;, 0: only
//   special characters); it is always ready. The user must write it only
//   while idle; the block itself does not enforce it. Each accepted byte is
//   expanded at once into a run of 1 to 6 bytes held in a run buffer; a
//   serializer moves one run byte per cycle into the output register while
//   the master side does not stall. The first result byte is registered in
//   the run buffer and then in the output register before it is valid.
//   The next input byte is taken in the cycle the last run byte moves out,
//   so plain bytes stream at one per cycle while the output is not stalled.
//   The output register is the only path to the master side, so a stall
//   there holds the run buffer and, once that is full, the slave side.
//   Reset clears the run and output valid flags, the run index and escape_all.
// ----------------------------------------------------------------------------
`include "html_escape_encoder_defines.svh"

module html_escape_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,     // escape_all
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  // Output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // run_end
  output logic       m_axis_tlast    // message_end
);
  import hee_pkg::*;

  logic                   esc_all_q;
  logic                   run_valid_q;
  logic [MaxRun-1:0][7:0] run_bytes_q;
  run_len_t               run_len_q;
  run_len_t               run_idx_q;
  logic                   run_last_q;
  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic                   out_run_end_q;
  logic                   out_msg_end_q;

  run_t run_d;
  logic in_fire;
  logic move;
  logic at_end;
  logic run_done;

  // Expand the incoming byte
  assign run_d = hee_expand(s_axis_tdata, esc_all_q);

  // Handshake and serializer control
  assign at_end        = (run_idx_q == run_len_q - 3'd1);
  assign move          = run_valid_q && (!out_valid_q || m_axis_tready);
  assign run_done      = move && at_end;
  assign s_axis_tready = !run_valid_q || run_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_all_q <= 1'b0;
    end else if (cfg_valid_i) begin
      esc_all_q <= cfg_data_i;
    end
  end

  // Run buffer: load on accept, advance one byte per move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
    end else if (in_fire) begin
      run_valid_q <= 1'b1;
      run_idx_q   <= '0;
    end else if (run_done) begin
      run_valid_q <= 1'b0;
    end else if (move) begin
      run_idx_q <= run_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      run_bytes_q <= run_d.bytes;
      run_len_q   <= run_d.len;
      run_last_q  <= s_axis_tlast;
    end
  end

  // Output register: take a run byte or drop the taken beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_byte_q    <= run_bytes_q[run_idx_q];
      out_run_end_q <= at_end;
      out_msg_end_q <= at_end && run_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_run_end_q;
  assign m_axis_tlast  = out_msg_end_q;

  // Checks
  `HEE_ASSERT_NOW(a_idx_in_run, run_valid_q, run_idx_q < run_len_q,
    "run index beyond run length")
  `HEE_ASSERT_NOW(a_len_range, run_valid_q,
    run_len_q != 3'd0 && run_len_q <= 3'd6, "run length out of range")
  `HEE_ASSERT_NOW(a_msg_end_run_end, out_valid_q && m_axis_tlast, m_axis_tuser,
    "message end without run end")
  `HEE_ASSERT_NEXT(a_advance, move && !at_end,
    run_valid_q && run_idx_q == $past(run_idx_q) + 3'd1,
    "serializer failed to advance")

endmodule
